// ===== rtl/core/pmwc_pkg.sv =====
// Shared types and constants for the pressure min/max window-change block.
`default_nettype none

package pmwc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CHANGE_W = 17;

    // Bits of the packed output tdata, rounded up to whole bytes
    localparam int OUT_DATA_W = ((3 * SAMPLE_W + CHANGE_W + 7) / 8) * 8;

    // Running minimum starts at 500 kPa in 0.01 kPa units
    localparam logic [SAMPLE_W-1:0] MIN_RESET_VALUE = 16'd50000;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CHANGE_W-1:0] change_t;

endpackage

`default_nettype wire

// ===== rtl/core/pressure_minmax_window_change.sv =====
// Top level: pressure min/max tracker with a moving-window sum of sample differences.
// An input transfer goes through stage 1 and the output register to the master side.
// Throughput: one item per cycle unless the output is blocked; the ring memory does
// one read-first access per item; the window sum updates once per item in stage two.
// Reset: rst_n clears control state, minimum to 500 kPa, maximum and sum to zero;
// ring entries not yet written since reset read as zero through a wrap flag.
`default_nettype none

module pressure_minmax_window_change #(
    parameter int WINDOW = 1200
) (
    input  wire         clk,
    input  wire         rst_n,
    // slave side
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    // master side
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [pmwc_pkg::OUT_DATA_W-1:0] m_tdata
    // m_tdata: [15:0] current_value, [31:16] lowest_value, [47:32] highest_value,
    // [64:48] window_change, upper bits zero
);

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    // Tracking state
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 wrapped_reg;
    pmwc_pkg::sample_t    prev_reg, min_reg, max_reg;
    pmwc_pkg::sample_t    min_next, max_next;
    pmwc_pkg::change_t    sum_reg, sum_next;

    // Stage 1 (memory read in flight)
    logic                 s1_valid_reg;
    pmwc_pkg::sample_t    s1_sample_reg, s1_min_reg, s1_max_reg;
    pmwc_pkg::change_t    s1_diff_reg;
    logic                 s1_old_valid_reg;

    // Output register
    logic                 out_valid_reg;
    pmwc_pkg::sample_t    out_current_reg, out_lowest_reg, out_highest_reg;
    pmwc_pkg::change_t    out_change_reg;

    pmwc_pkg::sample_t    sample;
    pmwc_pkg::change_t    diff;
    pmwc_pkg::change_t    ring_old;
    pmwc_pkg::change_t    old_entry;
    logic                 in_xfer, s1_move, out_free;

    assign sample   = s_tdata;
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_xfer  = s_tvalid && s_tready;

    // Difference to the previous sample, zero after reset or after a zero sample
    always_comb
    begin
        if (prev_reg == '0)
            diff = '0;
        else
            diff = {1'b0, sample} - {1'b0, prev_reg};
        min_next = (sample < min_reg) ? sample : min_reg;
        max_next = (sample > max_reg) ? sample : max_reg;
        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    end

    pmwc_ring #(
        .DEPTH  (WINDOW),
        .ADDR_W (POS_W)
    ) u_ring (
        .clk     (clk),
        .en      (in_xfer),
        .addr    (pos_reg),
        .wr_data (diff),
        .rd_data (ring_old)
    );

    // Drop the oldest entry and add the new difference
    assign old_entry = s1_old_valid_reg ? ring_old : '0;
    assign sum_next  = sum_reg - old_entry + s1_diff_reg;

    // Advance tracking state and stage 1 on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            wrapped_reg  <= 1'b0;
            prev_reg     <= '0;
            min_reg      <= pmwc_pkg::MIN_RESET_VALUE;
            max_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                pos_reg  <= pos_next;
                prev_reg <= sample;
                min_reg  <= min_next;
                max_reg  <= max_next;
                if (pos_reg == POS_LAST)
                    wrapped_reg <= 1'b1;
            end
            if (s_tready)
                s1_valid_reg <= in_xfer;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg    <= sample;
            s1_min_reg       <= min_next;
            s1_max_reg       <= max_next;
            s1_diff_reg      <= diff;
            s1_old_valid_reg <= wrapped_reg;
        end
    end

    // Window sum and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
                sum_reg <= sum_next;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_current_reg <= s1_sample_reg;
            out_lowest_reg  <= s1_min_reg;
            out_highest_reg <= s1_max_reg;
            out_change_reg  <= sum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pmwc_pkg::OUT_DATA_W'({out_change_reg, out_highest_reg,
                                             out_lowest_reg, out_current_reg});

    // Input stalls only when both stages are full and the output is blocked
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // Ring position stays inside the window
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("ring position out of range");

    // Running minimum never rises above its reset value
    a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        min_reg <= pmwc_pkg::MIN_RESET_VALUE)
        else $error("running minimum above reset value");

    // A shown result keeps its sample between minimum and maximum
    a_result_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_lowest_reg <= out_current_reg
                           && out_highest_reg >= out_current_reg))
        else $error("result sample outside min/max");

    // The pipeline moves stage 1 into the output register when there is room
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("stage 1 item lost");

endmodule

`default_nettype wire

// ===== rtl/core/pmwc_ring.sv =====
// Difference ring storage: single-port synchronous memory, read-first, registered read.
`default_nettype none

module pmwc_ring #(
    parameter int DEPTH  = 1200,
    parameter int ADDR_W = 11
) (
    input  wire                      clk,
    input  wire                      en,
    input  wire [ADDR_W-1:0]         addr,
    input  wire pmwc_pkg::change_t   wr_data,
    output pmwc_pkg::change_t        rd_data
);

    pmwc_pkg::change_t mem_reg [DEPTH];
    pmwc_pkg::change_t rd_data_reg;

    // Read the old entry and write the new one in the same transfer cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg   <= mem_reg[addr];
            mem_reg[addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
